### hw/rtl/cfeg_pkg.sv
package cfeg_pkg;

    localparam int TIME_BITS      = 32;
    localparam int GAIN_FRAC_BITS = 16;
    localparam int GAIN_BITS      = GAIN_FRAC_BITS + 1;
    localparam int APB_DATA_BITS  = 32;
    localparam int APB_ADDR_BITS  = 4;
    localparam int REG_IDX_BITS   = 2;
    localparam int FRONT_STAGES   = 3;
    localparam int PIPE_STAGES    = FRONT_STAGES + GAIN_FRAC_BITS + 1;

    localparam logic [GAIN_BITS-1:0] GAIN_ONE = GAIN_BITS'(1) << GAIN_FRAC_BITS;

    typedef enum logic [REG_IDX_BITS-1:0] {
        REG_CLIP_START      = 2'd0,
        REG_CLIP_LENGTH     = 2'd1,
        REG_FADE_IN_LENGTH  = 2'd2,
        REG_FADE_OUT_LENGTH = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [TIME_BITS-1:0] clip_start;
        logic [TIME_BITS-1:0] clip_length;
        logic [TIME_BITS-1:0] fade_in_length;
        logic [TIME_BITS-1:0] fade_out_length;
    } cfg_t;

    typedef struct packed {
        logic                 pre_start;
        logic [TIME_BITS-1:0] offset;
    } front_a_t;

    typedef struct packed {
        logic                 zero;
        logic                 in_act;
        logic [TIME_BITS-1:0] offset;
        logic [TIME_BITS-1:0] to_end;
    } front_b_t;

    typedef struct packed {
        logic                      zero;
        logic                      in_act;
        logic                      out_act;
        logic [TIME_BITS-1:0]      rem_in;
        logic [TIME_BITS-1:0]      rem_out;
        logic [GAIN_FRAC_BITS-1:0] q_in;
        logic [GAIN_FRAC_BITS-1:0] q_out;
    } div_t;

endpackage

### hw/rtl/cfeg_in_if.sv
interface cfeg_in_if import cfeg_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [TIME_BITS-1:0] time_now;

    modport source (output valid, output time_now, input ready);
    modport sink (input valid, input time_now, output ready);
endinterface

### hw/rtl/cfeg_out_if.sv
interface cfeg_out_if import cfeg_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [GAIN_BITS-1:0] gain;

    modport source (output valid, output gain, input ready);
    modport sink (input valid, input gain, output ready);
endinterface

### hw/rtl/cfeg_regs.sv
module cfeg_regs import cfeg_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready,
    output cfg_t                     cfg
);

    cfg_t                     cfg_reg;
    cfg_t                     cfg_next;
    reg_idx_t                 idx;
    logic                     wr;
    logic [TIME_BITS-1:0]     wval;

    assign idx    = reg_idx_t'(paddr[REG_IDX_BITS+1:2]);
    assign wr     = psel && penable && pwrite;
    assign wval   = pwdata[TIME_BITS-1:0];
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr)
        begin
            case (idx)
                REG_CLIP_START:      cfg_next.clip_start      = wval;
                REG_CLIP_LENGTH:     cfg_next.clip_length     = wval;
                REG_FADE_IN_LENGTH:  cfg_next.fade_in_length  = wval;
                REG_FADE_OUT_LENGTH: cfg_next.fade_out_length = wval;
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_CLIP_START:      prdata = APB_DATA_BITS'(cfg_reg.clip_start);
            REG_CLIP_LENGTH:     prdata = APB_DATA_BITS'(cfg_reg.clip_length);
            REG_FADE_IN_LENGTH:  prdata = APB_DATA_BITS'(cfg_reg.fade_in_length);
            REG_FADE_OUT_LENGTH: prdata = APB_DATA_BITS'(cfg_reg.fade_out_length);
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### hw/rtl/cfeg_front.sv
module cfeg_front import cfeg_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [FRONT_STAGES-1:0] en,
    input  logic                    in_valid,
    input  logic [TIME_BITS-1:0]    time_now,
    input  cfg_t                    cfg,
    output logic [FRONT_STAGES-1:0] vld,
    output div_t                    d_out
);

    front_a_t                a_reg;
    front_a_t                a_next;
    front_b_t                b_reg;
    front_b_t                b_next;
    div_t                    c_reg;
    div_t                    c_next;
    logic [FRONT_STAGES-1:0] vld_reg;
    logic [FRONT_STAGES-1:0] vld_next;
    logic [TIME_BITS:0]      diff;

    // The borrow of the subtraction tells whether the time lies before the start.
    assign diff = {1'b0, time_now} - {1'b0, cfg.clip_start};

    always_comb
    begin
        a_next.pre_start = diff[TIME_BITS];
        a_next.offset    = diff[TIME_BITS-1:0];

        b_next.zero   = a_reg.pre_start || (a_reg.offset >= cfg.clip_length);
        b_next.in_act = (cfg.fade_in_length != '0) && (a_reg.offset < cfg.fade_in_length);
        b_next.offset = a_reg.offset;
        b_next.to_end = cfg.clip_length - a_reg.offset;

        c_next.zero    = b_reg.zero;
        c_next.in_act  = b_reg.in_act;
        c_next.out_act = (cfg.fade_out_length != '0) && (b_reg.to_end < cfg.fade_out_length);
        c_next.rem_in  = b_reg.offset;
        c_next.rem_out = b_reg.to_end;
        c_next.q_in    = '0;
        c_next.q_out   = '0;

        vld_next[0] = en[0] ? in_valid : vld_reg[0];
        vld_next[1] = en[1] ? vld_reg[0] : vld_reg[1];
        vld_next[2] = en[2] ? vld_reg[1] : vld_reg[2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            a_reg <= a_next;
        end
        if (en[1])
        begin
            b_reg <= b_next;
        end
        if (en[2])
        begin
            c_reg <= c_next;
        end
    end

    assign vld   = vld_reg;
    assign d_out = c_reg;

endmodule

### hw/rtl/cfeg_div_cell.sv
module cfeg_div_cell import cfeg_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 valid_in,
    input  div_t                 d_in,
    input  logic [TIME_BITS-1:0] fade_in_length,
    input  logic [TIME_BITS-1:0] fade_out_length,
    output logic                 valid_out,
    output div_t                 d_out
);

    div_t               d_reg;
    div_t               d_next;
    logic               valid_reg;
    logic               valid_next;
    logic [TIME_BITS:0] sh_in;
    logic [TIME_BITS:0] sh_out;
    logic               ge_in;
    logic               ge_out;
    logic [TIME_BITS:0] sub_in;
    logic [TIME_BITS:0] sub_out;

    // One restoring step per lane yields one quotient bit of each fraction.
    always_comb
    begin
        sh_in   = {d_in.rem_in, 1'b0};
        sh_out  = {d_in.rem_out, 1'b0};
        ge_in   = sh_in >= {1'b0, fade_in_length};
        ge_out  = sh_out >= {1'b0, fade_out_length};
        sub_in  = sh_in - {1'b0, fade_in_length};
        sub_out = sh_out - {1'b0, fade_out_length};

        d_next         = d_in;
        d_next.rem_in  = ge_in ? sub_in[TIME_BITS-1:0] : sh_in[TIME_BITS-1:0];
        d_next.rem_out = ge_out ? sub_out[TIME_BITS-1:0] : sh_out[TIME_BITS-1:0];
        d_next.q_in    = {d_in.q_in[GAIN_FRAC_BITS-2:0], ge_in};
        d_next.q_out   = {d_in.q_out[GAIN_FRAC_BITS-2:0], ge_out};

        valid_next = en ? valid_in : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg <= d_next;
        end
    end

    assign valid_out = valid_reg;
    assign d_out     = d_reg;

endmodule

### hw/rtl/cfeg_out.sv
module cfeg_out import cfeg_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 valid_in,
    input  div_t                 d_in,
    output logic                 valid_out,
    output logic [GAIN_BITS-1:0] gain
);

    logic                 valid_reg;
    logic                 valid_next;
    logic [GAIN_BITS-1:0] gain_reg;
    logic [GAIN_BITS-1:0] gain_next;
    logic [GAIN_BITS-1:0] g_in;
    logic [GAIN_BITS-1:0] g_out;

    always_comb
    begin
        g_in  = d_in.in_act ? {1'b0, d_in.q_in} : GAIN_ONE;
        g_out = d_in.out_act ? {1'b0, d_in.q_out} : GAIN_ONE;
        if (d_in.zero)
        begin
            gain_next = '0;
        end
        else if (g_in < g_out)
        begin
            gain_next = g_in;
        end
        else
        begin
            gain_next = g_out;
        end
        valid_next = en ? valid_in : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            gain_reg <= gain_next;
        end
    end

    assign valid_out = valid_reg;
    assign gain      = gain_reg;

endmodule

### hw/rtl/clip_fade_envelope_gain.sv
// Envelope gain of one clip with linear fade-in and fade-out.
// Time stamps arrive as words on in_ch (time_now, in ticks) and each one gives
// exactly one word on out_ch (gain, unsigned Q1.16, where 65536 is unity).
// Clip start, clip length and both fade lengths: APB byte addresses 0, 4, 8
// and 12. Write only while no word is in flight; the block does not check.
// The pipeline has 20 register stages: three stages of offset and range
// checks, a chain of 16 divider cells that each produce one quotient bit of
// both fade fractions, and the output register. One word is accepted in
// every cycle while out_ch is ready.
// Each stage holds its word when the stage after it is full and cannot move,
// so a stalled receiver fills the empty stages first and in_ch.ready falls
// only when the whole chain is full; no word is lost or repeated.
// Reset clears all valid bits and sets every configuration register to zero,
// which makes the gain zero until a clip length is written.
module clip_fade_envelope_gain import cfeg_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    cfeg_in_if.sink                  in_ch,
    cfeg_out_if.source               out_ch,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready
);

    cfg_t                   cfg;
    logic [PIPE_STAGES-1:0] vld;
    logic [PIPE_STAGES-1:0] en;
    div_t                   d [0:GAIN_FRAC_BITS];

    cfeg_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign en[PIPE_STAGES-1] = !vld[PIPE_STAGES-1] || out_ch.ready;

    for (genvar i = 0; i < PIPE_STAGES - 1; i++)
    begin : g_en
        assign en[i] = !vld[i] || en[i+1];
    end

    assign in_ch.ready = en[0];

    cfeg_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en[FRONT_STAGES-1:0]),
        .in_valid (in_ch.valid),
        .time_now (in_ch.time_now),
        .cfg      (cfg),
        .vld      (vld[FRONT_STAGES-1:0]),
        .d_out    (d[0])
    );

    for (genvar k = 0; k < GAIN_FRAC_BITS; k++)
    begin : g_cell
        cfeg_div_cell u_cell
        (
            .clk             (clk),
            .rst_n           (rst_n),
            .en              (en[FRONT_STAGES+k]),
            .valid_in        (vld[FRONT_STAGES+k-1]),
            .d_in            (d[k]),
            .fade_in_length  (cfg.fade_in_length),
            .fade_out_length (cfg.fade_out_length),
            .valid_out       (vld[FRONT_STAGES+k]),
            .d_out           (d[k+1])
        );
    end

    cfeg_out u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en[PIPE_STAGES-1]),
        .valid_in  (vld[PIPE_STAGES-2]),
        .d_in      (d[GAIN_FRAC_BITS]),
        .valid_out (vld[PIPE_STAGES-1]),
        .gain      (out_ch.gain)
    );

    assign out_ch.valid = vld[PIPE_STAGES-1];

endmodule

### verif/clip_fade_envelope_gain_test.sv
module clip_fade_envelope_gain_test;
    import cfeg_pkg::*;

    localparam int QUIET_LIMIT = 4000;
    localparam int HOLD_CYCLES = 80;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_ADDR_BITS-1:0] paddr;
    logic [APB_DATA_BITS-1:0] pwdata;
    logic [APB_DATA_BITS-1:0] prdata;
    logic pready;

    cfeg_in_if  in_ch ();
    cfeg_out_if out_ch ();

    clip_fade_envelope_gain DUT
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    cfg_t                 clip_cfg;
    logic [GAIN_BITS-1:0] expected_gain[$];
    int                   fail_count;
    int                   quiet_cycles;
    int                   hold_seq;
    bit                   idling_on;

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    function automatic logic [GAIN_BITS-1:0] ramp_gain(input logic [TIME_BITS-1:0] num,
                                                       input logic [TIME_BITS-1:0] den);
        logic [63:0] quotient;
        quotient = (64'(num) << GAIN_FRAC_BITS) / 64'(den);
        return GAIN_BITS'(quotient);
    endfunction

    function automatic logic [GAIN_BITS-1:0] envelope_gain(input logic [TIME_BITS-1:0] t);
        logic [TIME_BITS-1:0] offset;
        logic [TIME_BITS-1:0] to_end;
        logic [GAIN_BITS-1:0] g;
        logic [GAIN_BITS-1:0] f;
        if (t < clip_cfg.clip_start)
            return '0;
        offset = t - clip_cfg.clip_start;
        if (offset >= clip_cfg.clip_length)
            return '0;
        g = GAIN_ONE;
        if (clip_cfg.fade_in_length != 0 && offset < clip_cfg.fade_in_length)
        begin
            f = ramp_gain(offset, clip_cfg.fade_in_length);
            if (f < g)
                g = f;
        end
        to_end = clip_cfg.clip_length - offset;
        if (clip_cfg.fade_out_length != 0 && to_end < clip_cfg.fade_out_length)
        begin
            f = ramp_gain(to_end, clip_cfg.fade_out_length);
            if (f < g)
                g = f;
        end
        return g;
    endfunction

    // Most time stamps land near the clip edges and inside the two ramps.
    function automatic logic [TIME_BITS-1:0] pick_time();
        logic [TIME_BITS-1:0] s;
        logic [TIME_BITS-1:0] l;
        s = clip_cfg.clip_start;
        l = clip_cfg.clip_length;
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return s - $urandom_range(1, 4);
            2, 3: return s + $urandom_range(0, clip_cfg.fade_in_length);
            4, 5: return s + l - $urandom_range(0, clip_cfg.fade_out_length);
            6: return s + l + $urandom_range(0, 2) - 1;
            default: return s + $urandom_range(0, l);
        endcase
    endfunction

    function automatic logic [TIME_BITS-1:0] rand_span(input int unsigned kind);
        case (kind)
            0: return $urandom_range(0, 16);
            1: return $urandom_range(17, 5000);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [TIME_BITS-1:0] rand_fade(input int unsigned kind,
                                                       input logic [TIME_BITS-1:0] len);
        case ($urandom_range(0, 3))
            0: return '0;
            1: return $urandom_range(0, len);
            2: return rand_span(kind);
            default: return $urandom;
        endcase
    endfunction

    task automatic write_reg(input reg_idx_t idx, input logic [TIME_BITS-1:0] value);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        case (idx)
            REG_CLIP_START:      clip_cfg.clip_start      = value;
            REG_CLIP_LENGTH:     clip_cfg.clip_length     = value;
            REG_FADE_IN_LENGTH:  clip_cfg.fade_in_length  = value;
            REG_FADE_OUT_LENGTH: clip_cfg.fade_out_length = value;
            default:             ;
        endcase
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic send_time(input logic [TIME_BITS-1:0] t);
        int gap;
        @(negedge clk);
        if (idling_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 4);
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid    = 1'b1;
        in_ch.time_now = t;
        do @(posedge clk); while (!in_ch.ready);
        expected_gain = {expected_gain, envelope_gain(t)};
    endtask

    task automatic settle();
        @(negedge clk);
        in_ch.valid = 1'b0;
        while (expected_gain.size() != 0)
            @(posedge clk);
    endtask

    task automatic apply_clip(input logic [TIME_BITS-1:0] s, input logic [TIME_BITS-1:0] l,
                              input logic [TIME_BITS-1:0] fi, input logic [TIME_BITS-1:0] fo);
        settle();
        write_reg(REG_CLIP_START, s);
        write_reg(REG_CLIP_LENGTH, l);
        write_reg(REG_FADE_IN_LENGTH, fi);
        write_reg(REG_FADE_OUT_LENGTH, fo);
    endtask

    task automatic apply_random_clip();
        int unsigned kind;
        logic [TIME_BITS-1:0] s;
        logic [TIME_BITS-1:0] l;
        kind = $urandom_range(0, 2);
        s = ($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(0, 100000);
        l = rand_span(kind);
        apply_clip(s, l, rand_fade(kind, l), rand_fade(kind, l));
    endtask

    task automatic test_reset_state();
        send_time('0);
        send_time('1);
        send_time(32'd1234);
    endtask

    task automatic test_directed_clips();
        apply_clip(32'd1000, 32'd500, 32'd100, 32'd200);
        send_time(32'd999);
        send_time(32'd1000);
        send_time(32'd1050);
        send_time(32'd1100);
        send_time(32'd1300);
        send_time(32'd1301);
        send_time(32'd1499);
        send_time(32'd1500);
        // Overlapping fades: the lower ramp decides.
        apply_clip(32'd0, 32'd100, 32'd80, 32'd80);
        send_time(32'd0);
        send_time(32'd50);
        send_time(32'd99);
        // Fades much longer than the clip never reach unity.
        apply_clip(32'd10, 32'd10, 32'd1000, 32'hFFFF_FFFF);
        send_time(32'd10);
        send_time(32'd19);
        // The clip end lies beyond the top of the time range.
        apply_clip(32'hFFFF_FF00, 32'hFFFF_FFFF, 32'd0, 32'd16);
        send_time(32'hFFFF_FFFF);
        send_time(32'hFFFF_FEFF);
        send_time(32'd0);
        apply_clip(32'd5, 32'd0, 32'd0, 32'd0);
        send_time(32'd5);
        apply_clip('1, '1, '1, '1);
        send_time(32'hFFFF_FFFF);
        send_time(32'hFFFF_FFFE);
    endtask

    task automatic test_random_clips();
        for (int phase = 0; phase < 8; phase++)
        begin
            apply_random_clip();
            for (int i = 0; i < 150; i++)
                send_time(pick_time());
        end
    endtask

    task automatic test_receiver_backpressure();
        apply_random_clip();
        hold_seq++;
        for (int i = 0; i < 60; i++)
            send_time(pick_time());
    endtask

    task automatic test_steady_stream();
        settle();
        idling_on = 1'b0;
        apply_random_clip();
        for (int i = 0; i < 200; i++)
            send_time(pick_time());
    endtask

    task automatic finish_run();
        settle();
        repeat (PIPE_STAGES + 4) @(posedge clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    endtask

    initial
    begin
        rst_n          = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.time_now = '0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        clip_cfg       = '0;
        fail_count     = 0;
        hold_seq       = 0;
        idling_on      = 1'b1;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_reset_state();
        test_directed_clips();
        test_random_clips();
        test_receiver_backpressure();
        test_steady_stream();
        finish_run();
    end

    initial
    begin : receiver
        int idle_left;
        int hold_left;
        int hold_seen;
        idle_left    = 0;
        hold_left    = 0;
        hold_seen    = 0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_seq != hold_seen)
            begin
                hold_seen = hold_seq;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_ch.ready = 1'b0;
                hold_left--;
            end
            else if (idle_left > 0)
            begin
                out_ch.ready = 1'b0;
                idle_left--;
            end
            else if (idling_on && $urandom_range(0, 5) == 0)
            begin
                out_ch.ready = 1'b0;
                idle_left = $urandom_range(0, 3);
            end
            else
                out_ch.ready = 1'b1;
        end
    end

    always @(posedge clk)
    begin : check_gain
        logic [GAIN_BITS-1:0] want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_gain.size() == 0)
            begin
                $error("gain: no word expected, got %0d", out_ch.gain);
                fail_count++;
            end
            else
            begin
                want = expected_gain.pop_front();
                if (out_ch.gain !== want)
                begin
                    $error("gain: expected %0d, got %0d", want, out_ch.gain);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

endmodule
